// ===== design/deadline_timer_table_assert.svh =====
// -----------------------------------------------------------------------------
// deadline_timer_table_assert.svh
// Assertion macros shared by the timer table design files.
// -----------------------------------------------------------------------------
`ifndef DEADLINE_TIMER_TABLE_ASSERT_SVH
`define DEADLINE_TIMER_TABLE_ASSERT_SVH

// Check the consequent in the same cycle as the antecedent.
`define DTT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define DTT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dtt_pkg.sv =====
// -----------------------------------------------------------------------------
// dtt_pkg
// Types, codes and sizes shared by the deadline timer table modules.
// -----------------------------------------------------------------------------
package dtt_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int SLOT_W      = $clog2(TIMER_SLOTS);
  localparam int FIRE_LIMIT  = 16;
  localparam int FIRE_W      = $clog2(FIRE_LIMIT);

  localparam int DL_W  = 48;
  localparam int ID_W  = 31;
  localparam int HDL_W = 16;

  // Input word kinds
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_ADD    = 2'd1;
  localparam logic [1:0] KIND_CANCEL = 2'd2;

  // Result word kinds
  localparam logic [1:0] RES_ADD_ACK    = 2'd0;
  localparam logic [1:0] RES_CANCEL_ACK = 2'd1;
  localparam logic [1:0] RES_FIRED      = 2'd2;

  typedef struct packed {
    logic [1:0]       kind;
    logic [DL_W-1:0]  deadline;
    logic [HDL_W-1:0] handle;
    logic [ID_W-1:0]  timer_id;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       result_kind;
    logic [ID_W-1:0]  timer_id_out;
    logic [HDL_W-1:0] handle_out;
    logic             ok;
    logic             last;
  } out_word_t;

  // Partial search result handed from cell to cell
  typedef struct packed {
    logic              id_hit;
    logic [SLOT_W-1:0] id_idx;
    logic              free_hit;
    logic [SLOT_W-1:0] free_idx;
    logic              due_hit;
    logic [SLOT_W-1:0] due_idx;
    logic [DL_W-1:0]   best_dl;
    logic [ID_W-1:0]   best_id;
    logic [HDL_W-1:0]  best_handle;
  } scan_t;

  // Search keys seen by every cell during a pass
  typedef struct packed {
    logic [ID_W-1:0] key_id;
    logic [DL_W-1:0] now;
  } bcast_t;

  // Slot update broadcast from the controller
  typedef struct packed {
    logic              wr;
    logic              clr;
    logic [SLOT_W-1:0] idx;
    logic [DL_W-1:0]   deadline;
    logic [ID_W-1:0]   id;
    logic [HDL_W-1:0]  handle;
  } cmd_t;

endpackage

// ===== design/deadline_timer_table.sv =====
// -----------------------------------------------------------------------------
// deadline_timer_table
// Table of one-shot timers that fire earliest deadline first on each tick.
// -----------------------------------------------------------------------------
//
//   channel  | direction | handshake           | word
//   ---------+-----------+---------------------+-----------
//   in_      | in        | in_valid/in_stall   | in_word_t
//   out_     | out       | out_valid/out_stall | out_word_t
//
// Search: every search is one pass of a word down the row of TIMER_SLOTS
// cells, one cell per cycle. An add or cancel takes one pass; a tick that
// fires k timers takes k + 1 passes, the last finding nothing due, except
// when FIRE_LIMIT fire: then FIRE_LIMIT passes and a final flush step.
// Reset: synchronous on rst_n low; all slots empty, time and id counters zero.
// Stalls: one output register; a held result blocks the next slot update
// but the search word just waits at the end of the row.
//
`include "deadline_timer_table_assert.svh"

module deadline_timer_table import dtt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  // search word at each hop; hop 0 comes from the sequencer, the last hop returns
  scan_t  chain [TIMER_SLOTS+1];
  bcast_t bcast;
  cmd_t   cmd;

  dtt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .scan_head (chain[0]),
    .bcast     (bcast),
    .scan_tail (chain[TIMER_SLOTS]),
    .cmd       (cmd)
  );

  // one cell per slot; each folds its entry into the passing search word
  for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
    dtt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (SLOT_W'(i)),
      .bcast    (bcast),
      .cmd      (cmd),
      .scan_in  (chain[i]),
      .scan_out (chain[i+1])
    );
  end

  // acknowledges carry no handle
  `DTT_ASSERT_SAME(a_ack_no_handle,
    out_valid && (out_word.result_kind != RES_FIRED),
    out_word.handle_out == '0, "acknowledge carries a handle")
  // a fired timer is always reported ok
  `DTT_ASSERT_SAME(a_fired_ok,
    out_valid && (out_word.result_kind == RES_FIRED),
    out_word.ok, "fired result without ok")
  // a refused add reports id zero
  `DTT_ASSERT_SAME(a_full_id_zero,
    out_valid && (out_word.result_kind == RES_ADD_ACK) && !out_word.ok,
    out_word.timer_id_out == '0, "refused add with nonzero id")
  // an accepted add or cancel always starts a search
  `DTT_ASSERT_NEXT(a_busy_after_item,
    in_valid && !in_stall && ((in_word.kind == KIND_ADD) || (in_word.kind == KIND_CANCEL)),
    in_stall, "add or cancel did not start a search")

endmodule

// ===== design/dtt_cell.sv =====
// -----------------------------------------------------------------------------
// dtt_cell
// One timer slot; folds its entry into the search word and passes it on.
// -----------------------------------------------------------------------------
module dtt_cell import dtt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SLOT_W-1:0] cell_idx,
  input  bcast_t            bcast,
  input  cmd_t              cmd,
  input  scan_t             scan_in,
  output scan_t             scan_out
);

  logic             valid_r;
  logic [DL_W-1:0]  dl_r;
  logic [ID_W-1:0]  id_r;
  logic [HDL_W-1:0] hdl_r;
  scan_t            scan_out_r;
  scan_t            scan_nxt;

  logic sel;
  logic id_match;
  logic due;
  logic better;

  assign sel = (cmd.idx == cell_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.wr && sel) begin
      valid_r <= 1'b1;
    end else if (cmd.clr && sel) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr && sel) begin
      dl_r  <= cmd.deadline;
      id_r  <= cmd.id;
      hdl_r <= cmd.handle;
    end
    scan_out_r <= scan_nxt;
  end

  assign id_match = valid_r && (id_r == bcast.key_id);
  assign due      = valid_r && (dl_r <= bcast.now);
  // earlier deadline wins, equal deadlines go to the smaller id
  assign better   = due && (!scan_in.due_hit || (dl_r < scan_in.best_dl) ||
                    ((dl_r == scan_in.best_dl) && (id_r < scan_in.best_id)));

  always_comb begin
    scan_nxt = scan_in;
    if (id_match && !scan_in.id_hit) begin
      scan_nxt.id_hit = 1'b1;
      scan_nxt.id_idx = cell_idx;
    end
    if (!valid_r && !scan_in.free_hit) begin
      scan_nxt.free_hit = 1'b1;
      scan_nxt.free_idx = cell_idx;
    end
    if (better) begin
      scan_nxt.due_hit     = 1'b1;
      scan_nxt.due_idx     = cell_idx;
      scan_nxt.best_dl     = dl_r;
      scan_nxt.best_id     = id_r;
      scan_nxt.best_handle = hdl_r;
    end
  end

  assign scan_out = scan_out_r;

endmodule

// ===== design/dtt_ctrl.sv =====
// -----------------------------------------------------------------------------
// dtt_ctrl
// Sequencer: launches search passes, updates slots and drives result words.
// -----------------------------------------------------------------------------
module dtt_ctrl import dtt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word,
  output scan_t     scan_head,
  output bcast_t    bcast,
  input  scan_t     scan_tail,
  output cmd_t      cmd
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE, ST_FLUSH} state_t;

  state_t            state_r,       state_nxt;
  logic [SLOT_W-1:0] cnt_r,         cnt_nxt;
  logic [1:0]        op_r,          op_nxt;
  logic [ID_W-1:0]   key_r,         key_nxt;
  logic [DL_W-1:0]   dl_r,          dl_nxt;
  logic [HDL_W-1:0]  hdl_r,         hdl_nxt;
  logic [DL_W-1:0]   now_r,         now_nxt;
  logic [ID_W-1:0]   next_id_r,     next_id_nxt;
  logic [FIRE_W-1:0] fire_cnt_r,    fire_cnt_nxt;
  logic              pend_valid_r,  pend_valid_nxt;
  logic [ID_W-1:0]   pend_id_r,     pend_id_nxt;
  logic [HDL_W-1:0]  pend_hdl_r,    pend_hdl_nxt;
  logic              out_valid_r,   out_valid_nxt;
  out_word_t         out_word_r,    out_word_nxt;

  logic accept;
  logic out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign scan_head = '0;
  assign bcast     = '{key_id: key_r, now: now_r};

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    dl_nxt         = dl_r;
    hdl_nxt        = hdl_r;
    now_nxt        = now_r;
    next_id_nxt    = next_id_r;
    fire_cnt_nxt   = fire_cnt_r;
    pend_valid_nxt = pend_valid_r;
    pend_id_nxt    = pend_id_r;
    pend_hdl_nxt   = pend_hdl_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_word_nxt   = out_word_r;
    cmd            = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt  = in_word.kind;
          dl_nxt  = in_word.deadline;
          hdl_nxt = in_word.handle;
          cnt_nxt = '0;
          unique case (in_word.kind)
            KIND_TICK: begin
              now_nxt      = now_r + DL_W'(1);
              fire_cnt_nxt = '0;
              state_nxt    = ST_SCAN;
            end
            KIND_ADD: begin
              key_nxt   = next_id_r;
              state_nxt = ST_SCAN;
            end
            KIND_CANCEL: begin
              key_nxt   = in_word.timer_id;
              state_nxt = ST_SCAN;
            end
            default: begin
              // drop unknown kinds
            end
          endcase
        end
      end

      ST_SCAN: begin
        cnt_nxt = cnt_r + SLOT_W'(1);
        if (cnt_r == SLOT_W'(TIMER_SLOTS - 1)) begin
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          unique case (op_r)
            KIND_ADD: begin
              out_valid_nxt = 1'b1;
              state_nxt     = ST_IDLE;
              if (scan_tail.id_hit || scan_tail.free_hit) begin
                cmd.wr       = 1'b1;
                cmd.idx      = scan_tail.id_hit ? scan_tail.id_idx : scan_tail.free_idx;
                cmd.deadline = dl_r;
                cmd.id       = next_id_r;
                cmd.handle   = hdl_r;
                next_id_nxt  = next_id_r + ID_W'(1);
                out_word_nxt = '{result_kind: RES_ADD_ACK, timer_id_out: next_id_r,
                                 handle_out: '0, ok: 1'b1, last: 1'b1};
              end else begin
                out_word_nxt = '{result_kind: RES_ADD_ACK, timer_id_out: '0,
                                 handle_out: '0, ok: 1'b0, last: 1'b1};
              end
            end
            KIND_CANCEL: begin
              cmd.clr       = scan_tail.id_hit;
              cmd.idx       = scan_tail.id_idx;
              out_valid_nxt = 1'b1;
              out_word_nxt  = '{result_kind: RES_CANCEL_ACK, timer_id_out: key_r,
                                handle_out: '0, ok: scan_tail.id_hit, last: 1'b1};
              state_nxt     = ST_IDLE;
            end
            default: begin
              if (scan_tail.due_hit) begin
                // hold the newest fired entry until the next pass shows if it is last
                cmd.clr = 1'b1;
                cmd.idx = scan_tail.due_idx;
                if (pend_valid_r) begin
                  out_valid_nxt = 1'b1;
                  out_word_nxt  = '{result_kind: RES_FIRED, timer_id_out: pend_id_r,
                                    handle_out: pend_hdl_r, ok: 1'b1, last: 1'b0};
                end
                pend_valid_nxt = 1'b1;
                pend_id_nxt    = scan_tail.best_id;
                pend_hdl_nxt   = scan_tail.best_handle;
                fire_cnt_nxt   = fire_cnt_r + FIRE_W'(1);
                cnt_nxt        = '0;
                if (fire_cnt_r == FIRE_W'(FIRE_LIMIT - 1)) begin
                  state_nxt = ST_FLUSH;
                end else begin
                  state_nxt = ST_SCAN;
                end
              end else begin
                if (pend_valid_r) begin
                  out_valid_nxt = 1'b1;
                  out_word_nxt  = '{result_kind: RES_FIRED, timer_id_out: pend_id_r,
                                    handle_out: pend_hdl_r, ok: 1'b1, last: 1'b1};
                end
                pend_valid_nxt = 1'b0;
                state_nxt      = ST_IDLE;
              end
            end
          endcase
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_word_nxt   = '{result_kind: RES_FIRED, timer_id_out: pend_id_r,
                             handle_out: pend_hdl_r, ok: 1'b1, last: 1'b1};
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      now_r        <= '0;
      next_id_r    <= '0;
      fire_cnt_r   <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      now_r        <= now_nxt;
      next_id_r    <= next_id_nxt;
      fire_cnt_r   <= fire_cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    cnt_r      <= cnt_nxt;
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    dl_r       <= dl_nxt;
    hdl_r      <= hdl_nxt;
    pend_id_r  <= pend_id_nxt;
    pend_hdl_r <= pend_hdl_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule

// ===== sim/deadline_timer_table_tb.sv =====
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// deadline_timer_table_tb
// Self-checking bench for the one-shot timer table with earliest-deadline firing.
// -----------------------------------------------------------------------------
// A short scripted sequence covers the corners first: the largest and the
// smallest field values, a cancel of an id that is not there, the unused
// kind, a deadline that is already past, a full table, and one tick that
// fires all sixteen entries, with ties on the deadline settled by id. Rows
// whose answer is plain carry it typed in; the rest go through the bench's
// own timer table model. A long random run follows with mostly sensible
// traffic: deadlines near the current time, cancels of live ids, and a few
// far deadlines that fill the table. Both sides idle at random, except in
// one long calm window; the sender also holds off once until the block has
// drained.
// -----------------------------------------------------------------------------
module deadline_timer_table_tb;
  import dtt_pkg::*;

  localparam logic [1:0] KIND_UNUSED  = 2'd3;
  localparam int         RANDOM_WORDS = 370;
  localparam int         SETTLE_CYCLES = 400;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  deadline_timer_table u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  // Free-running clock, 4 ns period.
  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Timer table model: its own copy of the slots, the time and the id counter.
  // ---------------------------------------------------------------------------
  logic             slot_live [TIMER_SLOTS];
  logic [DL_W-1:0]  slot_due  [TIMER_SLOTS];
  logic [ID_W-1:0]  slot_tag  [TIMER_SLOTS];
  logic [HDL_W-1:0] slot_hdl  [TIMER_SLOTS];
  logic [DL_W-1:0]  clock_now;
  logic [ID_W-1:0]  id_next;

  out_word_t step_results[$];     // words caused by the word just taken
  out_word_t pending_results[$];  // words still owed by the block, oldest first

  int  mismatches = 0;
  bit  calm       = 1'b0;         // no idling on either side while set

  function automatic out_word_t res(input logic [1:0] kind, input logic [ID_W-1:0] id,
                                    input logic [HDL_W-1:0] hdl, input logic ok,
                                    input logic last);
    out_word_t w;
    w.result_kind  = kind;
    w.timer_id_out = id;
    w.handle_out   = hdl;
    w.ok           = ok;
    w.last         = last;
    return w;
  endfunction

  function automatic void table_clear();
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      slot_live[i] = 1'b0;
      slot_due[i]  = '0;
      slot_tag[i]  = '0;
      slot_hdl[i]  = '0;
    end
    clock_now = '0;
    id_next   = '0;
  endfunction

  // Advance the model by one word and leave its results in step_results.
  function automatic void timer_table_step(input in_word_t w);
    int        pick;
    int        best;
    int        fired;
    logic      found;
    out_word_t tail;
    step_results.delete();
    case (w.kind)
      KIND_ADD: begin
        // Reuse a live slot holding the same id (only after wrap), else the
        // first free slot.
        pick = -1;
        for (int i = 0; i < TIMER_SLOTS; i++)
          if (pick < 0 && slot_live[i] && slot_tag[i] == id_next) pick = i;
        for (int i = 0; i < TIMER_SLOTS; i++)
          if (pick < 0 && !slot_live[i]) pick = i;
        if (pick < 0) begin
          step_results.push_back(res(RES_ADD_ACK, '0, '0, 1'b0, 1'b1));
        end else begin
          slot_live[pick] = 1'b1;
          slot_due[pick]  = w.deadline;
          slot_hdl[pick]  = w.handle;
          slot_tag[pick]  = id_next;
          step_results.push_back(res(RES_ADD_ACK, id_next, '0, 1'b1, 1'b1));
          id_next = id_next + 1'b1;
        end
      end
      KIND_CANCEL: begin
        found = 1'b0;
        for (int i = 0; i < TIMER_SLOTS; i++) begin
          if (!found && slot_live[i] && slot_tag[i] == w.timer_id) begin
            slot_live[i] = 1'b0;
            found        = 1'b1;
          end
        end
        step_results.push_back(res(RES_CANCEL_ACK, w.timer_id, '0, found, 1'b1));
      end
      KIND_TICK: begin
        clock_now = clock_now + 1'b1;
        fired     = 0;
        do begin
          best = -1;
          for (int i = 0; i < TIMER_SLOTS; i++) begin
            if (slot_live[i] && slot_due[i] <= clock_now) begin
              if (best < 0 || slot_due[i] < slot_due[best] ||
                  (slot_due[i] == slot_due[best] && slot_tag[i] < slot_tag[best]))
                best = i;
            end
          end
          if (best >= 0) begin
            slot_live[best] = 1'b0;
            step_results.push_back(res(RES_FIRED, slot_tag[best], slot_hdl[best],
                                       1'b1, 1'b0));
            fired++;
          end
        end while (best >= 0 && fired < FIRE_LIMIT);
        // Mark the final fired word of this tick.
        if (fired > 0) begin
          tail      = step_results.pop_back();
          tail.last = 1'b1;
          step_results.push_back(tail);
        end
      end
      default: ;  // unused kind: no words, no state change
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch report: one line each, all counted.
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("%0t ns: %s mismatch: got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Check each result word against the oldest owed word.
  always @(posedge clk) begin : result_check
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unowed result word", 64'(out_word), 64'(0));
      end else begin
        want = pending_results.pop_front();
        if (out_word.result_kind !== want.result_kind)
          flag_mismatch("result_kind", 64'(out_word.result_kind),
                        64'(want.result_kind));
        if (out_word.timer_id_out !== want.timer_id_out)
          flag_mismatch("timer_id_out", 64'(out_word.timer_id_out),
                        64'(want.timer_id_out));
        if (out_word.handle_out !== want.handle_out)
          flag_mismatch("handle_out", 64'(out_word.handle_out),
                        64'(want.handle_out));
        if (out_word.ok !== want.ok)
          flag_mismatch("ok", 64'(out_word.ok), 64'(want.ok));
        if (out_word.last !== want.last)
          flag_mismatch("last", 64'(out_word.last), 64'(want.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Idling on both sides, with odds of 16 in 100 outside the calm window.
  // ---------------------------------------------------------------------------
  function automatic bit idle_now();
    return !calm && ($urandom_range(0, 99) < 16);
  endfunction

  always @(negedge clk) begin
    out_stall <= idle_now();
  end

  function automatic in_word_t junk_word();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[$bits(in_word_t)-1:0];
  endfunction

  // Present one word at the falling edge, idle first at random, and hold it
  // until the block takes it at a rising edge.
  task automatic send_word(input in_word_t w);
    @(negedge clk);
    while (idle_now()) begin
      in_valid <= 1'b0;
      in_word  <= junk_word();
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // Drop valid and hold off until the block has delivered every owed word.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Scripted corner cases. n_typed: -1 take the model's words, 0 none owed,
  // 1 the typed word is owed.
  // ---------------------------------------------------------------------------
  typedef struct {
    in_word_t  w;
    int        n_typed;
    out_word_t typed;
  } script_row_t;

  script_row_t script[$];

  function automatic void add_row(input logic [1:0] kind, input logic [DL_W-1:0] dl,
                                  input logic [HDL_W-1:0] hdl, input logic [ID_W-1:0] id,
                                  input int n_typed, input out_word_t typed);
    script_row_t r;
    r.w.kind     = kind;
    r.w.deadline = dl;
    r.w.handle   = hdl;
    r.w.timer_id = id;
    r.n_typed    = n_typed;
    r.typed      = typed;
    script.push_back(r);
  endfunction

  function automatic void build_script();
    localparam logic [DL_W-1:0]  DL_MAX  = '1;
    localparam logic [HDL_W-1:0] HDL_MAX = '1;
    localparam logic [ID_W-1:0]  ID_MAX  = '1;
    // Cancel on an empty table: not found, the id comes back as given.
    add_row(KIND_CANCEL, DL_MAX, HDL_MAX, ID_MAX, 1,
            res(RES_CANCEL_ACK, ID_MAX, '0, 1'b0, 1'b1));
    // Tick with nothing due.
    add_row(KIND_TICK, DL_MAX, HDL_MAX, ID_MAX, 0, '0);
    // Unused kind with every other bit set: ignored.
    add_row(KIND_UNUSED, DL_MAX, HDL_MAX, ID_MAX, 0, '0);
    // Farthest deadline, then a deadline already past.
    add_row(KIND_ADD, DL_MAX, HDL_MAX, ID_MAX, 1, res(RES_ADD_ACK, 31'd0, '0, 1'b1, 1'b1));
    add_row(KIND_ADD, '0, '0, '0, 1, res(RES_ADD_ACK, 31'd1, '0, 1'b1, 1'b1));
    // The past one fires on the next tick, alone.
    add_row(KIND_TICK, '0, '0, '0, 1, res(RES_FIRED, 31'd1, '0, 1'b1, 1'b1));
    // Cancel the far one, then the same id again.
    add_row(KIND_CANCEL, '0, '0, 31'd0, 1, res(RES_CANCEL_ACK, 31'd0, '0, 1'b1, 1'b1));
    add_row(KIND_CANCEL, '0, '0, 31'd0, 1, res(RES_CANCEL_ACK, 31'd0, '0, 1'b0, 1'b1));
    // Fill every slot with deadlines 0..3 in a pattern that forces deadline ties.
    for (int i = 0; i < TIMER_SLOTS; i++)
      add_row(KIND_ADD, DL_W'(3 - (i % 4)), (i % 2) ? HDL_MAX : HDL_W'(i), ID_MAX, -1, '0);
    // Add on a full table: refused, id field zero.
    add_row(KIND_ADD, '0, HDL_MAX, ID_MAX, 1, res(RES_ADD_ACK, '0, '0, 1'b0, 1'b1));
    // One tick fires all sixteen, earliest first.
    add_row(KIND_TICK, '0, '0, '0, -1, '0);
  endfunction

  // Owe either the typed word, the model's words, or nothing.
  function automatic void owe_words(input script_row_t r);
    timer_table_step(r.w);
    if (r.n_typed == 1)
      pending_results.push_back(r.typed);
    else if (r.n_typed < 0)
      foreach (step_results[i]) pending_results.push_back(step_results[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Random traffic: mostly deadlines close to now and cancels of live ids.
  // ---------------------------------------------------------------------------
  function automatic in_word_t random_word();
    in_word_t         w;
    int               roll;
    int               k;
    logic [63:0]      r64;
    w   = junk_word();
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      w.kind = KIND_UNUSED;
    end else if (roll < 42) begin
      w.kind = KIND_TICK;
    end else if (roll < 75) begin
      w.kind = KIND_ADD;
      roll   = $urandom_range(0, 99);
      r64    = {$urandom, $urandom};
      if (roll < 65)
        w.deadline = clock_now + DL_W'($urandom_range(0, 24));
      else if (roll < 75)
        w.deadline = clock_now - DL_W'($urandom_range(0, 40));
      else if (roll < 90)
        w.deadline = r64[DL_W-1:0];
      else
        w.deadline = r64[0] ? '1 : '0;
    end else begin
      w.kind = KIND_CANCEL;
      roll   = $urandom_range(0, 99);
      k      = $urandom_range(0, TIMER_SLOTS - 1);
      if (roll < 60 && slot_live[k])
        w.timer_id = slot_tag[k];
      else if (roll < 85)
        w.timer_id = id_next - ID_W'($urandom_range(1, 20));
      // otherwise keep the random id
    end
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    script_row_t r;
    int          taken;
    table_clear();
    build_script();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      send_word(script[i].w);
      owe_words(script[i]);
    end

    taken = 0;
    while (taken < RANDOM_WORDS) begin
      calm = (taken >= 120 && taken < 220);
      if (taken == 300) drain_results();
      r.w       = random_word();
      r.n_typed = -1;
      r.typed   = '0;
      send_word(r.w);
      owe_words(r);
      if (r.w.kind != KIND_UNUSED) taken++;
    end

    // Wait for the owed words, then settle so that stray words show up.
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin : watchdog
    #3000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/dtt_pkg.sv
design/dtt_cell.sv
design/dtt_ctrl.sv
design/deadline_timer_table.sv
sim/deadline_timer_table_tb.sv
